@@ hw/rtl/sdiv_pkg.sv @@
package sdiv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int NUM_STEPS  = DATA_WIDTH;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } t_sdiv_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic signed [DATA_WIDTH-1:0] remainder;
        logic                         divide_by_zero;
        logic                         overflow;
    } t_sdiv_rsp;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] shf;
        logic [DATA_WIDTH-1:0] dvs;
        logic                  neg_q;
        logic                  neg_r;
        logic                  dz;
        logic                  ovf;
    } t_sdiv_work;

    function automatic logic [DATA_WIDTH-1:0] cond_negate(
        input logic [DATA_WIDTH-1:0] value,
        input logic                  neg
    );
        cond_negate = neg ? (~value + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value;
    endfunction

endpackage

@@ hw/rtl/signed_divide_with_remainder.sv @@
// Pipelined signed divider that returns the quotient truncated toward zero and
// a remainder with the sign of the dividend. It accepts one request every cycle
// while its result side is not stalled and passes each one through DATA_WIDTH + 2
// register stages. One stage takes the magnitudes and flags, one restoring
// stage per quotient bit follows, and a last stage restores the signs.
// Every stage moves on as soon as the stage after it has room, so a stalled
// result only holds back the requests queued behind it. A zero divisor gives
// quotient 0, the dividend as remainder, and sets divide_by_zero; the most
// negative dividend over minus one gives the dividend as quotient, remainder 0,
// and sets overflow.
module signed_divide_with_remainder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  sdiv_pkg::t_sdiv_req i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output sdiv_pkg::t_sdiv_rsp o_rsp
);
    import sdiv_pkg::*;

    logic       w_valid [0:NUM_STEPS];
    logic       w_ready [0:NUM_STEPS];
    t_sdiv_work w_work  [0:NUM_STEPS];

    sdiv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_req   (i_req),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_work  (w_work[0])
    );

    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
        sdiv_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_work  (w_work[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_work  (w_work[g+1])
        );
    end

    sdiv_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_STEPS]),
        .o_ready (w_ready[NUM_STEPS]),
        .i_work  (w_work[NUM_STEPS]),
        .o_valid (o_rsp_valid),
        .i_ready (i_rsp_ready),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.divide_by_zero && o_rsp.overflow))
        else $error("Divide by zero and overflow flagged together.");

    a_dz_zero_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.divide_by_zero) |-> (o_rsp.quotient == '0))
        else $error("Divide by zero result has a nonzero quotient.");

    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.overflow) |->
        (o_rsp.quotient == {1'b1, {(DATA_WIDTH-1){1'b0}}} && o_rsp.remainder == '0))
        else $error("Overflow result is not the wrapped quotient with zero remainder.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |-> (o_rsp_valid && !i_rsp_ready))
        else $error("Request refused while the result side is not stalled.");
`endif

endmodule

@@ hw/rtl/sdiv_prep.sv @@
module sdiv_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sdiv_pkg::t_sdiv_req  i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sdiv_pkg::t_sdiv_work o_work
);
    import sdiv_pkg::*;

    logic                  r_valid;
    t_sdiv_work            r_work;
    t_sdiv_work            n_work;
    logic                  w_neg_a;
    logic                  w_neg_b;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic                  w_dz;

    assign w_neg_a = i_req.dividend[DATA_WIDTH-1];
    assign w_neg_b = i_req.divisor[DATA_WIDTH-1];
    assign w_mag_b = cond_negate(i_req.divisor, w_neg_b);
    assign w_dz    = (i_req.divisor == '0);

    // A zero divisor is replaced by all ones, which yields a zero quotient and
    // leaves the dividend magnitude as the remainder.
    always_comb begin
        n_work.rem   = '0;
        n_work.shf   = cond_negate(i_req.dividend, w_neg_a);
        n_work.dvs   = w_dz ? '1 : w_mag_b;
        n_work.neg_q = w_neg_a ^ w_neg_b;
        n_work.neg_r = w_neg_a;
        n_work.dz    = w_dz;
        n_work.ovf   = (i_req.dividend == {1'b1, {(DATA_WIDTH-1){1'b0}}})
                       && (i_req.divisor == '1);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

@@ hw/rtl/sdiv_step.sv @@
module sdiv_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sdiv_pkg::t_sdiv_work i_work,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sdiv_pkg::t_sdiv_work o_work
);
    import sdiv_pkg::*;

    logic                  r_valid;
    t_sdiv_work            r_work;
    t_sdiv_work            n_work;
    logic [DATA_WIDTH-1:0] w_trial;
    logic                  w_ge;

    // The partial remainder stays below the divisor, so the shifted trial
    // value always fits in the data width.
    assign w_trial = {i_work.rem[DATA_WIDTH-2:0], i_work.shf[DATA_WIDTH-1]};
    assign w_ge    = (w_trial >= i_work.dvs);

    always_comb begin
        n_work     = i_work;
        n_work.rem = w_ge ? (w_trial - i_work.dvs) : w_trial;
        n_work.shf = {i_work.shf[DATA_WIDTH-2:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

@@ hw/rtl/sdiv_post.sv @@
module sdiv_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sdiv_pkg::t_sdiv_work i_work,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sdiv_pkg::t_sdiv_rsp  o_rsp
);
    import sdiv_pkg::*;

    logic      r_valid;
    t_sdiv_rsp r_rsp;
    t_sdiv_rsp n_rsp;

    always_comb begin
        n_rsp.quotient       = cond_negate(i_work.shf, i_work.neg_q);
        n_rsp.remainder      = cond_negate(i_work.rem, i_work.neg_r);
        n_rsp.divide_by_zero = i_work.dz;
        n_rsp.overflow       = i_work.ovf;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

@@ verif/tb_signed_divide_with_remainder.sv @@
`timescale 1ns / 100ps

module tb_signed_divide_with_remainder;

    import sdiv_pkg::*;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct {
        t_sdiv_req req;
        bit        drain_first;
    } t_pending_div;

    localparam t_word MOST_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_word MOST_POS  = ~MOST_NEG;
    localparam t_word MINUS_ONE = '1;
    localparam int    RANDOM_DIVS = 850;
    localparam int    CYCLE_LIMIT = 300000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_req_valid = 1'b0;
    logic      o_req_ready;
    t_sdiv_req i_req       = '0;
    logic      o_rsp_valid;
    logic      i_rsp_ready = 1'b0;
    t_sdiv_rsp o_rsp;

    t_pending_div pending_divs[$];
    t_sdiv_rsp    expected_divisions[$];
    int unsigned  req_gap     = 0;
    int unsigned  req_burst   = 0;
    int unsigned  rsp_stall   = 0;
    int unsigned  rsp_burst   = 0;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;

    signed_divide_with_remainder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_sdiv_rsp divide_toward_zero(input t_sdiv_req req);
        t_word     num;
        t_word     den;
        t_word     mag_num;
        t_word     mag_den;
        t_word     mag_quo;
        t_word     mag_rem;
        logic      neg_num;
        logic      neg_den;
        t_sdiv_rsp rsp;
        num     = req.dividend;
        den     = req.divisor;
        neg_num = num[DATA_WIDTH-1];
        neg_den = den[DATA_WIDTH-1];
        rsp     = '0;
        if (den == '0) begin
            rsp.quotient       = '0;
            rsp.remainder      = num;
            rsp.divide_by_zero = 1'b1;
        end else begin
            mag_num       = neg_num ? -num : num;
            mag_den       = neg_den ? -den : den;
            mag_quo       = mag_num / mag_den;
            mag_rem       = mag_num % mag_den;
            rsp.quotient  = (neg_num != neg_den) ? -mag_quo : mag_quo;
            rsp.remainder = neg_num ? -mag_rem : mag_rem;
            rsp.overflow  = (num == MOST_NEG) && (den == MINUS_ONE);
        end
        return rsp;
    endfunction

    function automatic int unsigned pick_idle(inout int unsigned burst_left);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (roll < 2) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_word random_operand();
        t_word value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                value = t_word'({$urandom, $urandom});
            end
            4, 5: begin
                value = t_word'($urandom_range(0, 2000)) - t_word'(1000);
            end
            6, 7: begin
                value = t_word'({$urandom, $urandom}) >> $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1)) value = -value;
            end
            8: begin
                case ($urandom_range(0, 4))
                    0: value = MOST_NEG;
                    1: value = MOST_POS;
                    2: value = MINUS_ONE;
                    3: value = '0;
                    default: value = t_word'(1);
                endcase
            end
            default: begin
                value = t_word'(1) << $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1)) value = -value;
            end
        endcase
        return value;
    endfunction

    task automatic queue_div(input t_word dividend, input t_word divisor, input bit drain_first);
        t_pending_div item;
        item.req.dividend = dividend;
        item.req.divisor  = divisor;
        item.drain_first  = drain_first;
        pending_divs.push_back(item);
    endtask

    // The expected result is computed when a request is first presented, which is
    // always before its response can be seen.
    always @(posedge i_clk) begin : drive_requests
        t_pending_div next_div;
        logic         waiting;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            waiting = i_req_valid && !o_req_ready;
            if (!waiting) begin
                if (req_gap > 0) begin
                    req_gap--;
                    i_req_valid <= 1'b0;
                end else if (pending_divs.size() > 0 &&
                             !(pending_divs[0].drain_first && expected_divisions.size() > 0)) begin
                    next_div = pending_divs.pop_front();
                    expected_divisions.push_back(divide_toward_zero(next_div.req));
                    i_req       <= next_div.req;
                    i_req_valid <= 1'b1;
                    req_gap = pick_idle(req_burst);
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_sdiv_rsp want;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid === 1'b1 && i_rsp_ready) begin
                if (expected_divisions.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got q=%0d r=%0d dz=%b ovf=%b",
                             $time, o_rsp.quotient, o_rsp.remainder,
                             o_rsp.divide_by_zero, o_rsp.overflow);
                    error_count++;
                end else begin
                    want = expected_divisions.pop_front();
                    if (o_rsp.quotient !== want.quotient) begin
                        $display("%0t: quotient mismatch, expected %0d, got %0d",
                                 $time, want.quotient, o_rsp.quotient);
                        error_count++;
                    end
                    if (o_rsp.remainder !== want.remainder) begin
                        $display("%0t: remainder mismatch, expected %0d, got %0d",
                                 $time, want.remainder, o_rsp.remainder);
                        error_count++;
                    end
                    if (o_rsp.divide_by_zero !== want.divide_by_zero) begin
                        $display("%0t: divide_by_zero mismatch, expected %b, got %b",
                                 $time, want.divide_by_zero, o_rsp.divide_by_zero);
                        error_count++;
                    end
                    if (o_rsp.overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %b, got %b",
                                 $time, want.overflow, o_rsp.overflow);
                        error_count++;
                    end
                end
            end
            if (rsp_stall > 0) begin
                rsp_stall--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
                rsp_stall = pick_idle(rsp_burst);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_word dividend;
        t_word divisor;
        int    roll;

        queue_div(MOST_POS, MOST_POS, 1'b0);
        queue_div(MOST_NEG, MOST_NEG, 1'b0);
        queue_div(MOST_NEG, MINUS_ONE, 1'b0);
        queue_div(MOST_NEG, t_word'(1), 1'b0);
        queue_div(MOST_POS, MINUS_ONE, 1'b0);
        queue_div('0, '0, 1'b0);
        queue_div(MOST_NEG, '0, 1'b0);
        queue_div(MOST_POS, '0, 1'b0);
        queue_div(MINUS_ONE, '0, 1'b0);
        queue_div(t_word'(7), t_word'(2), 1'b0);
        queue_div(t_word'(-7), t_word'(2), 1'b0);
        queue_div(t_word'(7), t_word'(-2), 1'b0);
        queue_div(t_word'(-7), t_word'(-2), 1'b0);
        queue_div('0, t_word'(5), 1'b0);
        queue_div(t_word'(1), MOST_NEG, 1'b0);
        queue_div(MOST_NEG, MOST_POS, 1'b0);
        queue_div(MOST_POS, MOST_NEG, 1'b0);
        queue_div(MINUS_ONE, MOST_NEG, 1'b0);
        queue_div(t_word'(3), t_word'(7), 1'b0);
        queue_div(t_word'(-3), t_word'(7), 1'b0);
        queue_div(MOST_NEG, t_word'(2), 1'b0);
        queue_div(MOST_NEG, t_word'(-2), 1'b0);
        queue_div(MOST_POS, t_word'(1), 1'b0);

        for (int i = 0; i < RANDOM_DIVS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                dividend = random_operand();
                divisor  = '0;
            end else if (roll < 5) begin
                dividend = MOST_NEG;
                divisor  = MINUS_ONE;
            end else begin
                dividend = random_operand();
                divisor  = random_operand();
            end
            queue_div(dividend, divisor, (i == 0) || ($urandom_range(0, 99) == 0));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_divs.size() > 0 || i_req_valid || expected_divisions.size() > 0)
            @(posedge i_clk);
        repeat (DATA_WIDTH + 10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
